[hw/rtl/lhc_pkg.sv]
// ----------------------------------------------------------------------------
// lhc_pkg
// Shared types and constants of the last heard caller list: table size,
// entry row layout, alias slice layout, register indexes and control states.
// ----------------------------------------------------------------------------
`default_nettype none

package lhc_pkg;

  localparam int ENTRIES     = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SLICES      = 4;
  localparam int SLICE_W     = 2;
  localparam int SLICE_BYTES = 7;
  localparam int ALIAS_W     = SLICE_BYTES * 8;
  localparam int ALIAS_AW    = IDX_W + SLICE_W;
  localparam int ID_W        = 24;
  localparam int TGT_W       = 32;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [IDX_W-1:0] TAIL_RANK = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(ENTRIES);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_CALL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_CALL = 1'b1;

  // Alias block frame types.
  localparam logic [7:0] ALIAS_BLOCK_FIRST = 8'h04;
  localparam logic [7:0] ALIAS_BLOCK_LAST  = 8'h07;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TGT_W-1:0]   target;
    logic [TIME_W-1:0]  heard;
    logic [IDX_W-1:0]   rank;
    logic [SLICES-1:0]  slices;
  } ent_row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_ALIAS_RD,
    ST_ALIAS_WR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/lhc_ifs.sv]
// ----------------------------------------------------------------------------
// lhc channel interfaces
// Valid/ready channels for incoming frames, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lhc_frame_if;
  import lhc_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        frame_type;
  logic [7:0]        byte_2;
  logic [7:0]        byte_3;
  logic [7:0]        byte_4;
  logic [7:0]        byte_5;
  logic [7:0]        byte_6;
  logic [7:0]        byte_7;
  logic [7:0]        byte_8;
  logic [TIME_W-1:0] now_ms;

  modport source (
    output valid, kind, frame_type, byte_2, byte_3, byte_4, byte_5, byte_6,
           byte_7, byte_8, now_ms,
    input  ready
  );
  modport sink (
    input  valid, kind, frame_type, byte_2, byte_3, byte_4, byte_5, byte_6,
           byte_7, byte_8, now_ms,
    output ready
  );
endinterface

interface lhc_result_if;
  import lhc_pkg::*;
  logic              valid;
  logic              ready;
  logic              changed;
  logic              refresh_display;
  logic [ID_W-1:0]   front_caller;
  logic [TGT_W-1:0]  front_target;
  logic [TIME_W-1:0] front_time;
  logic              alias_stored;

  modport source (
    output valid, changed, refresh_display, front_caller, front_target,
           front_time, alias_stored,
    input  ready
  );
  modport sink (
    input  valid, changed, refresh_display, front_caller, front_target,
           front_time, alias_stored,
    output ready
  );
endinterface

interface lhc_cfg_if;
  import lhc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/lhc_ram.sv]
// ----------------------------------------------------------------------------
// lhc_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/last_heard_caller_lru_list.sv]
// A call frame with a new id or a changed target runs a read sweep of the entry RAM
// for the lookup, then a read-modify-write sweep for ranks, before its result is valid.
// A repeated id that is not in the table skips the second sweep. Alias frames read
// and then write the slice; other frames go straight to the result.
// One item at a time; the next is accepted in the cycle after the result is registered.
// Reset is synchronous; entry valid bits make unwritten entries read as reset values.
// ----------------------------------------------------------------------------
// last_heard_caller_lru_list
// Most-recent-first table of heard callers kept in an entry RAM with one
// recency rank per entry, plus an alias RAM holding one row per alias slice.
// ----------------------------------------------------------------------------
`default_nettype none

module last_heard_caller_lru_list (
  input wire logic   clk,
  input wire logic   rst,
  lhc_frame_if.sink    frame,
  lhc_result_if.source result,
  lhc_cfg_if.sink      cfg
);
  import lhc_pkg::*;

  state_t state, state_next;

  // Configuration registers.
  logic [7:0] group_call_code;
  logic [7:0] private_call_code;

  // Captured item.
  logic [7:0]        cap_ft;
  logic [7:0]        cap_b2, cap_b3, cap_b4, cap_b5, cap_b6, cap_b7, cap_b8;
  logic [TIME_W-1:0] cap_now;
  logic [ID_W-1:0]   cap_id;
  logic [TGT_W-1:0]  cap_target;
  logic              repeat_id;

  logic [ID_W-1:0]  last_caller;
  logic [TGT_W-1:0] last_target;

  // Sweep control.
  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [IDX_W-1:0] rd_idx;
  logic             phase_end;

  // Lookup results.
  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [IDX_W-1:0] best_rank;
  logic [IDX_W-1:0] tail_idx;

  // Update plan.
  logic [IDX_W-1:0] upd_e;
  logic [IDX_W-1:0] upd_r;
  logic             upd_move;
  logic             upd_load;

  // Front entry shadow.
  logic [IDX_W-1:0]  front_idx;
  logic [ID_W-1:0]   front_caller;
  logic [TGT_W-1:0]  front_target;
  logic [TIME_W-1:0] front_time;

  logic [ENTRIES-1:0] ent_valid;

  // RAM ports.
  logic             ent_re, ent_we;
  logic [IDX_W-1:0] ent_raddr;
  ent_row_t         ent_rdata, ent_wdata, eff_row, upd_row, alias_row;
  logic                alias_re, alias_we;
  logic [ALIAS_AW-1:0] alias_addr;
  logic [ALIAS_W-1:0]  alias_rdata, alias_wdata;
  logic [SLICE_W-1:0]  slice;
  logic [7:0]          slice_head;
  logic                head_empty;

  // Flags of the item in work; they reach the result register only when it is free.
  logic itm_changed, itm_refresh, itm_stored;

  // Result register.
  logic res_valid, res_changed, res_refresh, res_stored;
  logic [ID_W-1:0]   res_caller;
  logic [TGT_W-1:0]  res_target;
  logic [TIME_W-1:0] res_time;
  logic res_free;

  // Incoming item decode.
  logic             accept;
  logic [ID_W-1:0]  in_id;
  logic [TGT_W-1:0] in_target;
  logic             in_call, in_alias, in_news;

  assign accept    = frame.valid && frame.ready;
  assign in_id     = {frame.byte_6, frame.byte_7, frame.byte_8};
  assign in_target = {frame.frame_type, frame.byte_3, frame.byte_4, frame.byte_5};
  assign in_call   = !frame.kind && (frame.frame_type == group_call_code ||
                                     frame.frame_type == private_call_code);
  assign in_alias  = !frame.kind && !in_call &&
                     frame.frame_type >= ALIAS_BLOCK_FIRST &&
                     frame.frame_type <= ALIAS_BLOCK_LAST;
  assign in_news   = in_id != last_caller || in_target != last_target;

  assign phase_end = (cnt == SWEEP_END) && !pend;
  assign res_free  = !res_valid || result.ready;
  assign slice     = cap_ft[SLICE_W-1:0];
  assign alias_addr = {front_idx, slice};

  // An entry that was never written reads as its reset value.
  always_comb begin
    if (ent_valid[rd_idx]) begin
      eff_row = ent_rdata;
    end else begin
      eff_row        = '0;
      eff_row.rank   = rd_idx;
    end
  end

  // Row written back during the rank sweep.
  always_comb begin
    upd_row = eff_row;
    if (rd_idx == upd_e) begin
      upd_row.target = cap_target;
      upd_row.heard  = cap_now;
      if (upd_move) begin
        upd_row.rank = '0;
      end
      if (upd_load) begin
        upd_row.id     = cap_id;
        upd_row.slices = '0;
      end
    end else if (upd_move && eff_row.rank < upd_r) begin
      upd_row.rank = eff_row.rank + 1'b1;
    end
  end

  // A slice counts as empty while its slice bit is clear or its first byte is zero.
  assign slice_head = eff_row.slices[slice] ? alias_rdata[ALIAS_W-1 -: 8] : 8'h00;
  assign head_empty = slice_head == 8'h00;

  always_comb begin
    alias_row               = eff_row;
    alias_row.slices[slice] = 1'b1;
  end

  always_comb begin
    if (slice == '0) begin
      alias_wdata = {cap_b3, cap_b4, cap_b5, cap_b6, cap_b7, cap_b8, 8'h00};
    end else begin
      alias_wdata = {cap_b2, cap_b3, cap_b4, cap_b5, cap_b6, cap_b7, cap_b8};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (frame.kind) begin
            state_next = ST_DONE;
          end else if (in_call) begin
            state_next = in_news ? ST_SCAN : ST_DONE;
          end else if (in_alias) begin
            state_next = ST_ALIAS_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (phase_end) begin
          state_next = (repeat_id && !found) ? ST_DONE : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (phase_end) begin
          state_next = ST_DONE;
        end
      end
      ST_ALIAS_RD: state_next = ST_ALIAS_WR;
      ST_ALIAS_WR: state_next = ST_DONE;
      ST_DONE: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs: handshake and RAM port control.
  always_comb begin
    frame.ready = 1'b0;
    ent_re      = 1'b0;
    ent_raddr   = cnt[IDX_W-1:0];
    alias_re    = 1'b0;
    ent_we      = 1'b0;
    ent_wdata   = upd_row;
    alias_we    = 1'b0;
    unique case (state)
      ST_IDLE: frame.ready = 1'b1;
      ST_SCAN: ent_re = cnt < SWEEP_END;
      ST_UPDATE: begin
        ent_re = cnt < SWEEP_END;
        ent_we = pend;
      end
      ST_ALIAS_RD: begin
        ent_re    = 1'b1;
        ent_raddr = front_idx;
        alias_re  = 1'b1;
      end
      ST_ALIAS_WR: begin
        ent_we    = head_empty;
        ent_wdata = alias_row;
        alias_we  = head_empty;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign cfg.ready = 1'b1;

  lhc_ram #(
    .WIDTH ($bits(ent_row_t)),
    .DEPTH (ENTRIES)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (rd_idx),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  lhc_ram #(
    .WIDTH (ALIAS_W),
    .DEPTH (ENTRIES * SLICES)
  ) u_alias_ram (
    .clk   (clk),
    .we    (alias_we),
    .waddr (alias_addr),
    .wdata (alias_wdata),
    .re    (alias_re),
    .raddr (alias_addr),
    .rdata (alias_rdata)
  );

  // Captured item payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cap_ft     <= frame.frame_type;
      cap_b2     <= frame.byte_2;
      cap_b3     <= frame.byte_3;
      cap_b4     <= frame.byte_4;
      cap_b5     <= frame.byte_5;
      cap_b6     <= frame.byte_6;
      cap_b7     <= frame.byte_7;
      cap_b8     <= frame.byte_8;
      cap_now    <= frame.now_ms;
      cap_id     <= in_id;
      cap_target <= in_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      group_call_code   <= 8'd0;
      private_call_code <= 8'd3;
      last_caller       <= '0;
      last_target       <= '0;
      repeat_id         <= 1'b0;
      cnt               <= '0;
      pend              <= 1'b0;
      rd_idx            <= '0;
      found             <= 1'b0;
      best_idx          <= '0;
      best_rank         <= '0;
      tail_idx          <= '0;
      upd_e             <= '0;
      upd_r             <= '0;
      upd_move          <= 1'b0;
      upd_load          <= 1'b0;
      front_idx         <= '0;
      front_caller      <= '0;
      front_target      <= '0;
      front_time        <= '0;
      ent_valid         <= '0;
      itm_changed       <= 1'b0;
      itm_refresh       <= 1'b0;
      itm_stored        <= 1'b0;
      res_valid         <= 1'b0;
      res_changed       <= 1'b0;
      res_refresh       <= 1'b0;
      res_stored        <= 1'b0;
      res_caller        <= '0;
      res_target        <= '0;
      res_time          <= '0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        unique case (cfg.index)
          REG_GROUP_CALL:   group_call_code   <= cfg.data;
          REG_PRIVATE_CALL: private_call_code <= cfg.data;
        endcase
      end

      if (accept) begin
        cnt         <= '0;
        found       <= 1'b0;
        itm_changed <= in_call && in_news;
        itm_refresh <= 1'b0;
        itm_stored  <= 1'b0;
        repeat_id   <= in_id == last_caller;
        if (frame.kind) begin
          last_caller <= '0;
        end else if (in_call) begin
          last_caller <= in_id;
          last_target <= in_target;
        end
      end

      pend <= ent_re;
      if (ent_re) begin
        rd_idx <= ent_raddr;
        if (state == ST_SCAN || state == ST_UPDATE) begin
          cnt <= cnt + 1'b1;
        end
      end

      // Lookup: the matching entry nearest the front, and the tail entry.
      if (state == ST_SCAN && pend) begin
        if (eff_row.id == cap_id && (!found || eff_row.rank < best_rank)) begin
          found     <= 1'b1;
          best_idx  <= rd_idx;
          best_rank <= eff_row.rank;
        end
        if (eff_row.rank == TAIL_RANK) begin
          tail_idx <= rd_idx;
        end
      end

      if (state == ST_SCAN && phase_end) begin
        cnt <= '0;
        if (repeat_id) begin
          // Same caller, new target: update in place without moving.
          upd_e    <= best_idx;
          upd_r    <= '0;
          upd_move <= 1'b0;
          upd_load <= 1'b0;
        end else if (found) begin
          upd_e       <= best_idx;
          upd_r       <= best_rank;
          upd_move    <= best_rank != '0;
          upd_load    <= 1'b0;
          itm_refresh <= best_rank == '0 || cap_target != '0;
        end else begin
          upd_e       <= tail_idx;
          upd_r       <= TAIL_RANK;
          upd_move    <= 1'b1;
          upd_load    <= 1'b1;
          itm_refresh <= cap_target != '0;
        end
      end

      if (ent_we) begin
        ent_valid[rd_idx] <= 1'b1;
        if (ent_wdata.rank == '0) begin
          front_idx    <= rd_idx;
          front_caller <= ent_wdata.id;
          front_target <= ent_wdata.target;
          front_time   <= ent_wdata.heard;
        end
      end

      if (state == ST_ALIAS_WR && head_empty) begin
        itm_stored  <= 1'b1;
        itm_refresh <= 1'b1;
      end

      if (state == ST_DONE && res_free) begin
        res_valid   <= 1'b1;
        res_changed <= itm_changed;
        res_refresh <= itm_refresh;
        res_stored  <= itm_stored;
        res_caller  <= front_caller;
        res_target  <= front_target;
        res_time    <= front_time;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result.valid           = res_valid;
  assign result.changed         = res_changed;
  assign result.refresh_display = res_refresh;
  assign result.front_caller    = res_caller;
  assign result.front_target    = res_target;
  assign result.front_time      = res_time;
  assign result.alias_stored    = res_stored;

endmodule

`default_nettype wire

[hw/rtl/lhc_checker.sv]
// ----------------------------------------------------------------------------
// lhc_checker
// Port-level assertions for the last heard caller list, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lhc_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    frame_valid,
  input wire logic                    frame_ready,
  input wire logic                    result_valid,
  input wire logic                    result_ready,
  input wire logic                    changed,
  input wire logic                    refresh_display,
  input wire logic                    alias_stored,
  input wire logic [lhc_pkg::ID_W-1:0] front_caller
);
  import lhc_pkg::*;

  // Items are worked one at a time, so ready drops after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |=> !frame_ready)
    else $error("frame accepted while previous item still in work");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(front_caller))
    else $error("stalled result changed");

  // An alias write never comes with a caller change and always redraws.
  a_alias_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && alias_stored |-> refresh_display && !changed)
    else $error("alias_stored with inconsistent flags");

  // A redraw has a cause: either a caller change or an alias write.
  a_refresh_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && refresh_display |-> changed || alias_stored)
    else $error("refresh_display without a cause");

endmodule

bind last_heard_caller_lru_list lhc_checker u_lhc_checker (
  .clk             (clk),
  .rst             (rst),
  .frame_valid     (frame.valid),
  .frame_ready     (frame.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .changed         (result.changed),
  .refresh_display (result.refresh_display),
  .alias_stored    (result.alias_stored),
  .front_caller    (result.front_caller)
);

`default_nettype wire
